>>> rtl/core/eiph_pkg.sv
// Shared types, constants and helpers for the Ethernet/IP/TCP header parser.
`default_nettype none

package eiph_pkg;

	localparam logic [15:0] ET_IPV4       = 16'h0800;
	localparam logic [15:0] ET_IPV6       = 16'h86DD;
	localparam int          ETH_HDR_BYTES = 14;
	localparam int          MIN_HDR_BYTES = 20;
	localparam int          TCP_OFF_BYTE  = 12;
	localparam logic [5:0]  IPV6_HDR_BYTES = 6'd40;

	localparam logic [7:0] PROTO_HOPOPT = 8'd0;
	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] PROTO_IPV6   = 8'd41;
	localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

	typedef enum logic [3:0] {
		ST_TCP        = 4'd0,
		ST_UDP        = 4'd1,
		ST_ICMP       = 4'd2,
		ST_ICMPV6     = 4'd3,
		ST_IP         = 4'd4,
		ST_IPV6       = 4'd5,
		ST_OTHER      = 4'd6,
		ST_UNKNOWN_ET = 4'd7,
		ST_BAD_IP     = 4'd8,
		ST_BAD_TCP    = 4'd9,
		ST_TRUNC      = 4'd10
	} status_t;

	// Per-frame header fields gathered so far.
	typedef struct packed {
		logic [15:0] eth_type;
		logic [5:0]  net_hdr_len;
		logic [15:0] ip_len;
		logic [7:0]  proto;
		logic [31:0] ports;
		logic [5:0]  seg_hdr_len;
		logic        bad_ip;
	} frame_fields_t;

	typedef struct packed {
		logic [31:0] frame_number;
		status_t     status;
		logic        is_ipv6;
		logic [15:0] eth_type;
		logic [7:0]  protocol_number;
		logic [5:0]  ip_header_bytes;
		logic [5:0]  tcp_header_bytes;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] payload_bytes;
	} result_t;

	function automatic status_t proto_status(input logic [7:0] p);
		status_t s;
		case (p)
			PROTO_TCP:    s = ST_TCP;
			PROTO_UDP:    s = ST_UDP;
			PROTO_ICMP:   s = ST_ICMP;
			PROTO_ICMPV6: s = ST_ICMPV6;
			PROTO_HOPOPT: s = ST_IP;
			PROTO_IPV6:   s = ST_IPV6;
			default:      s = ST_OTHER;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/eiph_capture.sv
// Byte counter, frame counter and header field capture registers.
`default_nettype none

module eiph_capture import eiph_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 16383,
	parameter int IDX_W           = 14
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          data,
	input  wire logic                eof,
	output frame_fields_t            fields_next,
	output logic [IDX_W-1:0]         count_next,
	output logic [31:0]              frame_cnt
);

	localparam int W = IDX_W + 2;
	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_FRAME_BYTES);

	logic [IDX_W-1:0] idx_q;
	logic [31:0]      frame_cnt_q;
	frame_fields_t    fields_q;

	logic             in_range;
	logic [W-1:0]     pos_w;
	logic [W-1:0]     seg_base;
	logic [W-1:0]     seg_off;

	always_comb begin
		in_range    = (idx_q != MAX_IDX);
		pos_w       = W'(idx_q);
		fields_next = fields_q;
		count_next  = in_range ? idx_q + IDX_W'(1) : MAX_IDX;
		seg_base    = '0;
		seg_off     = '0;
		if (in_range) begin
			if (pos_w == W'(12)) begin
				fields_next.eth_type = {data, 8'h00};
			end
			if (pos_w == W'(13)) begin
				fields_next.eth_type[7:0] = data;
				if ({fields_q.eth_type[15:8], data} == ET_IPV6) begin
					fields_next.net_hdr_len = IPV6_HDR_BYTES;
				end
			end
			if (fields_q.eth_type == ET_IPV4 && pos_w >= W'(ETH_HDR_BYTES)) begin
				if (pos_w == W'(14)) begin
					fields_next.net_hdr_len = {data[3:0], 2'b00};
					if ({data[3:0], 2'b00} < 6'(MIN_HDR_BYTES)) begin
						fields_next.bad_ip = 1'b1;
					end
				end
				if (pos_w == W'(16)) fields_next.ip_len[15:8] = data;
				if (pos_w == W'(17)) fields_next.ip_len[7:0]  = data;
				if (pos_w == W'(23)) fields_next.proto        = data;
			end
			if (fields_q.eth_type == ET_IPV6 && pos_w >= W'(ETH_HDR_BYTES)) begin
				if (pos_w == W'(18)) fields_next.ip_len[15:8] = data;
				if (pos_w == W'(19)) fields_next.ip_len[7:0]  = data;
				if (pos_w == W'(20)) fields_next.proto        = data;
			end
			// The TCP header starts right after the network header.
			seg_base = W'(ETH_HDR_BYTES) + W'(fields_next.net_hdr_len);
			seg_off  = pos_w - seg_base;
			if (fields_next.net_hdr_len >= 6'(MIN_HDR_BYTES) && pos_w >= seg_base) begin
				if (seg_off < W'(4)) begin
					fields_next.ports = {fields_q.ports[23:0], data};
				end
				if (seg_off == W'(TCP_OFF_BYTE)) begin
					fields_next.seg_hdr_len = {data[7:4], 2'b00};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			frame_cnt_q <= '0;
			fields_q    <= '0;
		end else if (step) begin
			if (eof) begin
				idx_q       <= '0;
				fields_q    <= '0;
				frame_cnt_q <= frame_cnt_q + 32'd1;
			end else begin
				idx_q    <= count_next;
				fields_q <= fields_next;
			end
		end
	end

	assign frame_cnt = frame_cnt_q;

endmodule

`default_nettype wire

>>> rtl/core/eiph_classify.sv
// End-of-frame classification: status, lengths and ports of one result word.
`default_nettype none

module eiph_classify import eiph_pkg::*; #(
	parameter int IDX_W = 14
) (
	input  wire frame_fields_t       fields,
	input  wire logic [IDX_W-1:0]    count,
	input  wire logic [31:0]         frame_cnt,
	output result_t                  result
);

	localparam int W = IDX_W + 2;

	logic [W-1:0]  n_w;
	logic [W-1:0]  hdr_end;
	logic [W-1:0]  seg_end;
	logic          known;
	logic          v4;
	logic          v6;
	logic          show_ip;
	logic          show_tcp;
	status_t       st;
	logic [6:0]    sub;
	logic [15:0]   payload;

	always_comb begin
		n_w      = W'(count);
		hdr_end  = W'(ETH_HDR_BYTES) + W'(fields.net_hdr_len);
		seg_end  = hdr_end + W'(fields.seg_hdr_len);
		known    = (n_w >= W'(ETH_HDR_BYTES));
		v4       = known && (fields.eth_type == ET_IPV4);
		v6       = known && (fields.eth_type == ET_IPV6);
		show_ip  = 1'b0;
		show_tcp = 1'b0;
		sub      = 7'(fields.seg_hdr_len) + (v4 ? 7'(fields.net_hdr_len) : 7'd0);
		payload  = (fields.ip_len > 16'(sub)) ? fields.ip_len - 16'(sub) : 16'd0;

		if (!known) begin
			st = ST_TRUNC;
		end else if (!v4 && !v6) begin
			st = ST_UNKNOWN_ET;
		end else if (v4 && n_w < W'(ETH_HDR_BYTES + 1)) begin
			st = ST_TRUNC;
		end else if (fields.bad_ip) begin
			st = ST_BAD_IP;
		end else if (n_w < hdr_end) begin
			st = ST_TRUNC;
		end else begin
			st      = proto_status(fields.proto);
			show_ip = 1'b1;
			if (st == ST_TCP) begin
				if (n_w < hdr_end + W'(TCP_OFF_BYTE + 1)) begin
					st      = ST_TRUNC;
					show_ip = 1'b0;
				end else if (fields.seg_hdr_len < 6'(MIN_HDR_BYTES)) begin
					st = ST_BAD_TCP;
				end else if (n_w < seg_end) begin
					st      = ST_TRUNC;
					show_ip = 1'b0;
				end else begin
					show_tcp = 1'b1;
				end
			end
		end

		result              = '0;
		result.frame_number = frame_cnt;
		result.status       = st;
		if (known) begin
			result.is_ipv6  = v6;
			result.eth_type = fields.eth_type;
		end
		if (st == ST_BAD_IP) begin
			result.ip_header_bytes = fields.net_hdr_len;
		end
		if (show_ip) begin
			result.protocol_number = fields.proto;
			result.ip_header_bytes = fields.net_hdr_len;
		end
		if (st == ST_BAD_TCP) begin
			result.tcp_header_bytes = fields.seg_hdr_len;
		end
		if (show_tcp) begin
			result.tcp_header_bytes = fields.seg_hdr_len;
			result.source_port      = fields.ports[31:16];
			result.dest_port        = fields.ports[15:0];
			result.payload_bytes    = payload;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ethernet_ip_tcp_header_parser.sv
// A byte is taken into the input register and parsed from it there; an end-of-frame result
// is then written to the output register, from which it can be taken.
// Throughput: one frame byte per cycle, set by the single parse stage between the
// input register and the result register; a held result stalls only end-of-frame bytes.
// Reset: arst_n clears the byte and frame counters, all captured header fields
// and both valid flags; the block can take a byte as soon as reset is released.
`default_nettype none

module ethernet_ip_tcp_header_parser import eiph_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 16383
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_frame,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      frame_number,
	output logic [3:0]       status,
	output logic             is_ipv6,
	output logic [15:0]      eth_type,
	output logic [7:0]       protocol_number,
	output logic [5:0]       ip_header_bytes,
	output logic [5:0]       tcp_header_bytes,
	output logic [15:0]      source_port,
	output logic [15:0]      dest_port,
	output logic [15:0]      payload_bytes
);

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             eof_s1;
	logic             out_valid_q;
	result_t          result_q;

	logic             in_take;
	logic             advance;
	logic             fire;
	frame_fields_t    fields_next;
	logic [IDX_W-1:0] count_next;
	logic [31:0]      frame_cnt;
	result_t          result_next;

	// Only an end-of-frame word needs room in the result register.
	assign advance  = valid_s1 && (!eof_s1 || !out_valid_q || !out_stall);
	assign fire     = advance && eof_s1;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			eof_s1  <= end_of_frame;
		end
	end

	eiph_capture #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.IDX_W           (IDX_W)
	) u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data        (data_s1),
		.eof         (eof_s1),
		.fields_next (fields_next),
		.count_next  (count_next),
		.frame_cnt   (frame_cnt)
	);

	eiph_classify #(
		.IDX_W (IDX_W)
	) u_classify (
		.fields    (fields_next),
		.count     (count_next),
		.frame_cnt (frame_cnt),
		.result    (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_number     = result_q.frame_number;
	assign status           = 4'(result_q.status);
	assign is_ipv6          = result_q.is_ipv6;
	assign eth_type         = result_q.eth_type;
	assign protocol_number  = result_q.protocol_number;
	assign ip_header_bytes  = result_q.ip_header_bytes;
	assign tcp_header_bytes = result_q.tcp_header_bytes;
	assign source_port      = result_q.source_port;
	assign dest_port        = result_q.dest_port;
	assign payload_bytes    = result_q.payload_bytes;

`ifndef SYNTHESIS
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && eof_s1 && out_valid_q)
		else $error("input stalled without a pending end-of-frame word");

	a_frame_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> frame_cnt == $past(frame_cnt) + 32'd1)
		else $error("frame counter did not advance with a result");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> count_next <= IDX_W'(MAX_FRAME_BYTES))
		else $error("byte count beyond frame limit");

	a_tcp_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status == ST_TCP |->
			result_q.tcp_header_bytes >= 6'(MIN_HDR_BYTES))
		else $error("TCP result with short TCP header");
`endif

endmodule

`default_nettype wire
